>>> rtl/dla_pkg.sv
package dla_pkg;

    // Fixed field widths of the stream words.
    localparam int STATE_W     = 6;
    localparam int BYTE_W      = 8;
    localparam int CLASS_W     = 8;
    localparam int LEN_W       = 17;
    localparam int BYTE_VALUES = 256;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 24;

    // Queue depths between the parts.
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // Defaults for the top-level parameters.
    localparam int STATE_COUNT_DEF = 64;
    localparam int CLASS_COUNT_DEF = 256;
    localparam int MAX_LENGTH_DEF  = 65536;

    // Command codes carried in tuser.
    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_MAP   = 2'd1,
        CMD_TRANS = 2'd2,
        CMD_FINAL = 2'd3
    } cmd_e;

    // One class map entry.
    typedef struct packed {
        logic               valid;
        logic [CLASS_W-1:0] code;
    } map_entry_t;

    // One transition entry.
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] to;
    } trans_entry_t;

    // A word as it travels from the front to the back.
    typedef struct packed {
        cmd_e               cmd;
        logic [BYTE_W-1:0]  char_byte;
        logic               eos;
        logic [STATE_W-1:0] from_state;
        logic [CLASS_W-1:0] class_code;
        logic [STATE_W-1:0] to_state;
        logic               entry_valid;
        logic               final_flag;
        map_entry_t         map;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [LEN_W-1:0] prefix_length;
        logic             accepted;
        logic             length_overflow;
    } result_t;

endpackage

>>> rtl/dla_ram.sv
module dla_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 256
    )
    (
        input  logic                     aclk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic                     re,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; a read returns the old data
    // when it meets a write to the same address.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dla_queue.sv
module dla_queue
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 4
    )
    (
        input  logic                       aclk,
        input  logic                       aresetn,
        input  logic                       push,
        input  logic [WIDTH-1:0]           push_data,
        input  logic                       pop,
        output logic [WIDTH-1:0]           pop_data,
        output logic                       full,
        output logic                       empty,
        output logic [$clog2(DEPTH+1)-1:0] count
    );

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = data_reg[rd_ptr_reg];
    assign push_ok  = push && !full;
    assign pop_ok   = pop && !empty;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop_ok) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push_ok && !pop_ok) begin
            count_next = count_reg + CW'(1);
        end else if (pop_ok && !push_ok) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/dla_front.sv
module dla_front
    import dla_pkg::*;
    (
        input  logic              aclk,
        input  logic              aresetn,
        input  logic              clr_active,
        input  logic [BYTE_W-1:0] clr_addr,
        input  logic              in_valid,
        output logic              in_ready,
        input  item_t             in_item,
        input  logic              q_full,
        output logic              q_push,
        output item_t             q_data
    );

    logic       f_valid_reg, f_valid_next;
    item_t      f_item_reg, f_item_next;
    logic       accept;
    logic       map_we;
    logic [BYTE_W-1:0] map_waddr;
    map_entry_t map_wdata;
    logic       map_re;
    logic [$bits(map_entry_t)-1:0] map_rdata;

    assign accept   = in_valid && in_ready;
    assign q_push   = f_valid_reg && !q_full;
    assign in_ready = !clr_active && (!f_valid_reg || !q_full);

    // Class map writes finish here; every other word moves on to the queue.
    always_comb begin
        f_valid_next = f_valid_reg;
        f_item_next  = f_item_reg;
        if (accept) begin
            f_valid_next = (in_item.cmd != CMD_MAP);
            f_item_next  = in_item;
        end else if (q_push) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        f_item_reg <= f_item_next;
    end

    // Class map port: the clearing pass, then map writes; reads on characters.
    always_comb begin
        map_we    = clr_active || (accept && in_item.cmd == CMD_MAP);
        map_waddr = clr_active ? clr_addr : in_item.char_byte;
        map_wdata = clr_active ? map_entry_t'('0)
                               : map_entry_t'{valid: in_item.entry_valid,
                                              code: in_item.class_code};
        map_re    = accept && in_item.cmd == CMD_CHAR;
    end

    dla_ram #(
        .WIDTH ($bits(map_entry_t)),
        .DEPTH (BYTE_VALUES)
    ) u_class_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (in_item.char_byte),
        .rdata (map_rdata)
    );

    // The looked-up class rides along with the character word.
    always_comb begin
        q_data     = f_item_reg;
        q_data.map = map_entry_t'(map_rdata);
    end

    // A stalled word and its looked-up class must hold until the queue takes it.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid_reg && q_full |=> f_valid_reg && $stable(f_item_reg))
        else $error("front word changed while stalled");

endmodule

>>> rtl/dla_back.sv
module dla_back
    import dla_pkg::*;
    #(
        parameter int STATE_COUNT = STATE_COUNT_DEF,
        parameter int CLASS_COUNT = CLASS_COUNT_DEF,
        parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
        parameter int CLR_W       = 14
    )
    (
        input  logic                           aclk,
        input  logic                           aresetn,
        input  logic                           clr_active,
        input  logic [CLR_W-1:0]               clr_addr,
        input  logic [STATE_W-1:0]             init_state,
        input  logic                           q_empty,
        input  item_t                          q_head,
        output logic                           q_pop,
        input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
        output logic                           res_push,
        output result_t                        res_data
    );

    localparam int TRANS_DEPTH = STATE_COUNT * CLASS_COUNT;
    localparam int TA_W        = $clog2(TRANS_DEPTH);
    localparam int FA_W        = $clog2(STATE_COUNT);
    localparam int POS_W       = $clog2(MAX_LENGTH + 1);
    localparam int OC_W        = $clog2(OUT_DEPTH + 1);

    // String state.
    logic [STATE_W-1:0] cur_state_reg, cur_state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               ovf_reg, ovf_next;
    logic               halted_reg, halted_next;
    logic [POS_W-1:0]   best_reg, best_next;

    // Transition stage and final-flag stage.
    logic               b_valid_reg, b_valid_next;
    logic               b_eos_reg, b_eos_next;
    logic               b_lookup_reg, b_lookup_next;
    logic [POS_W-1:0]   b_pos_reg, b_pos_next;
    logic               b_ovf_reg, b_ovf_next;
    logic               c_valid_reg, c_valid_next;
    logic               c_eos_reg, c_eos_next;
    logic               c_hit_reg, c_hit_next;
    logic [POS_W-1:0]   c_pos_reg, c_pos_next;
    logic               c_ovf_reg, c_ovf_next;

    logic               is_char;
    logic               credit_ok;
    logic               char_go;
    logic               first_byte;
    logic [STATE_W-1:0] eff_state;
    logic               sat;
    logic [POS_W-1:0]   pos_inc;
    logic               ovf_inc;
    logic               lookup;
    logic               hit;
    logic               is_fin;
    logic [POS_W-1:0]   len;
    trans_entry_t       trans_entry;

    logic                     trans_we;
    logic [TA_W-1:0]          trans_waddr;
    trans_entry_t             trans_wdata;
    logic [TA_W-1:0]          trans_raddr;
    logic [$bits(trans_entry_t)-1:0] trans_rdata;
    logic                     fin_we;
    logic [FA_W-1:0]          fin_waddr;
    logic                     fin_wdata;
    logic [0:0]               fin_rdata;

    // Issue: take a word when no character is in the transition stage, and
    // hold a string's last character back until the output has room for it.
    always_comb begin
        is_char   = (q_head.cmd == CMD_CHAR);
        credit_ok = ({1'b0, out_count} + {{OC_W{1'b0}}, c_valid_reg && c_eos_reg})
                    < (OC_W + 1)'(OUT_DEPTH);
        q_pop     = !q_empty && !b_valid_reg && (!is_char || !q_head.eos || credit_ok);
        char_go   = q_pop && is_char;
    end

    // Character issue: start state, position count and lookup checks.
    always_comb begin
        first_byte = (pos_reg == '0) && !ovf_reg;
        eff_state  = first_byte ? init_state : cur_state_reg;
        sat        = (pos_reg == POS_W'(MAX_LENGTH));
        pos_inc    = sat ? pos_reg : pos_reg + POS_W'(1);
        ovf_inc    = ovf_reg || sat;
        lookup     = !halted_reg && q_head.map.valid
                     && (32'(q_head.map.code) < CLASS_COUNT)
                     && (32'(eff_state) < STATE_COUNT);
        trans_raddr = TA_W'(TA_W'(eff_state) * TA_W'(CLASS_COUNT)
                            + TA_W'(q_head.map.code));
    end

    // Transition stage: the new state, or a halt.
    always_comb begin
        trans_entry = trans_entry_t'(trans_rdata);
        hit         = b_lookup_reg && trans_entry.valid;
    end

    // Final-flag stage: the result of a string's last character.
    always_comb begin
        is_fin   = c_hit_reg && fin_rdata[0];
        len      = is_fin ? c_pos_reg : best_reg;
        res_push = c_valid_reg && c_eos_reg;
        res_data = result_t'{prefix_length:   LEN_W'(len),
                             accepted:        is_fin,
                             length_overflow: c_ovf_reg};
    end

    // Next values of the string state and the stages.
    always_comb begin
        cur_state_next = cur_state_reg;
        pos_next       = pos_reg;
        ovf_next       = ovf_reg;
        halted_next    = halted_reg;
        best_next      = best_reg;
        b_valid_next   = char_go;
        b_eos_next     = q_head.eos;
        b_lookup_next  = lookup;
        b_pos_next     = pos_inc;
        b_ovf_next     = ovf_inc;
        c_valid_next   = b_valid_reg;
        c_eos_next     = b_eos_reg;
        c_hit_next     = hit && (32'(trans_entry.to) < STATE_COUNT);
        c_pos_next     = b_pos_reg;
        c_ovf_next     = b_ovf_reg;

        // A string's last character starts the next string at once.
        if (char_go) begin
            cur_state_next = eff_state;
            pos_next       = q_head.eos ? '0 : pos_inc;
            ovf_next       = q_head.eos ? 1'b0 : ovf_inc;
            halted_next    = q_head.eos ? 1'b0 : (halted_reg || !lookup);
        end

        if (b_valid_reg && !b_eos_reg) begin
            if (hit) begin
                cur_state_next = trans_entry.to;
            end else if (b_lookup_reg) begin
                halted_next = 1'b1;
            end
        end

        if (c_valid_reg) begin
            best_next = c_eos_reg ? '0 : len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_state_reg <= '0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            halted_reg    <= 1'b0;
            best_reg      <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
        end else begin
            cur_state_reg <= cur_state_next;
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            halted_reg    <= halted_next;
            best_reg      <= best_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
        end
    end

    // Stage payload needs no reset.
    always_ff @(posedge aclk) begin
        b_eos_reg    <= b_eos_next;
        b_lookup_reg <= b_lookup_next;
        b_pos_reg    <= b_pos_next;
        b_ovf_reg    <= b_ovf_next;
        c_eos_reg    <= c_eos_next;
        c_hit_reg    <= c_hit_next;
        c_pos_reg    <= c_pos_next;
        c_ovf_reg    <= c_ovf_next;
    end

    // Table write ports: the clearing pass, then transition and final writes.
    always_comb begin
        if (clr_active) begin
            trans_we    = (32'(clr_addr) < TRANS_DEPTH);
            trans_waddr = clr_addr[TA_W-1:0];
            trans_wdata = trans_entry_t'('0);
            fin_we      = (32'(clr_addr) < STATE_COUNT);
            fin_waddr   = clr_addr[FA_W-1:0];
            fin_wdata   = 1'b0;
        end else begin
            trans_we    = q_pop && q_head.cmd == CMD_TRANS
                          && (32'(q_head.from_state) < STATE_COUNT)
                          && (32'(q_head.class_code) < CLASS_COUNT);
            trans_waddr = TA_W'(TA_W'(q_head.from_state) * TA_W'(CLASS_COUNT)
                                + TA_W'(q_head.class_code));
            trans_wdata = q_head.entry_valid
                          ? trans_entry_t'{valid: 1'b1, to: q_head.to_state}
                          : trans_entry_t'('0);
            fin_we      = q_pop && q_head.cmd == CMD_FINAL
                          && (32'(q_head.from_state) < STATE_COUNT);
            fin_waddr   = FA_W'(q_head.from_state);
            fin_wdata   = q_head.final_flag;
        end
    end

    dla_ram #(
        .WIDTH ($bits(trans_entry_t)),
        .DEPTH (TRANS_DEPTH)
    ) u_trans_ram (
        .aclk  (aclk),
        .we    (trans_we),
        .waddr (trans_waddr),
        .wdata (trans_wdata),
        .re    (char_go),
        .raddr (trans_raddr),
        .rdata (trans_rdata)
    );

    dla_ram #(
        .WIDTH (1),
        .DEPTH (STATE_COUNT)
    ) u_final_ram (
        .aclk  (aclk),
        .we    (fin_we),
        .waddr (fin_waddr),
        .wdata (fin_wdata),
        .re    (b_valid_reg),
        .raddr (FA_W'(trans_entry.to)),
        .rdata (fin_rdata)
    );

    // A character leaves the transition stage before the next one enters it.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(b_valid_reg && c_valid_reg))
        else $error("two characters overlap in the back stages");

endmodule

>>> rtl/dfa_longest_accepting_prefix.sv
// Table-driven DFA matcher that reports, for every string, the length of its
// longest accepting prefix, whether the whole string was accepted, and whether
// the string ran past MAX_LENGTH characters. Words on the input stream carry a
// command in s_tuser: characters (s_tlast on the last one of a string) or
// writes to the class map, the transition table and the final-state flags;
// writes take effect for the very next word. Each string's last character
// yields one result word. The back end takes no new character until the one
// before it has left the transition stage, since the state loop runs through
// the transition memory (registered read, then the new state picks the next
// address); table writes are taken back to back, and class map writes do not
// occupy the back end at all. A four-word queue separates the front end from
// the back end, and a two-word output queue lets input flow on while a result
// waits. After reset a clearing pass over max(STATE_COUNT*CLASS_COUNT, 256)
// addresses empties the tables while s_tready stays low; the start state can
// be written at any time.
module dfa_longest_accepting_prefix
    import dla_pkg::*;
    #(
        parameter int STATE_COUNT = STATE_COUNT_DEF,
        parameter int CLASS_COUNT = CLASS_COUNT_DEF,
        parameter int MAX_LENGTH  = MAX_LENGTH_DEF
    )
    (
        input  logic                 aclk,
        input  logic                 aresetn,
        input  logic                 cfg_wr_en,
        input  logic [STATE_W-1:0]   cfg_wr_data,   // start state
        input  logic                 s_tvalid,
        output logic                 s_tready,
        // char_byte[7:0], from_state[13:8], class_code[21:14], to_state[27:22],
        // entry_valid[28], final_flag[29], zero[31:30]
        input  logic [S_TDATA_W-1:0] s_tdata,
        input  logic                 s_tlast,       // end_of_string
        input  logic [1:0]           s_tuser,       // cmd[1:0]
        output logic                 m_tvalid,
        input  logic                 m_tready,
        // prefix_length[16:0], accepted[17], length_overflow[18], zero[23:19]
        output logic [M_TDATA_W-1:0] m_tdata
    );

    localparam int TRANS_DEPTH = STATE_COUNT * CLASS_COUNT;
    localparam int CLR_DEPTH   = (TRANS_DEPTH > BYTE_VALUES) ? TRANS_DEPTH : BYTE_VALUES;
    localparam int CLR_W       = $clog2(CLR_DEPTH);

    logic [STATE_W-1:0] init_state_reg, init_state_next;
    logic               clr_active_reg, clr_active_next;
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;

    item_t   in_item;
    logic    q_full, q_empty, q_push, q_pop;
    item_t   q_data;
    logic [$bits(item_t)-1:0] q_head_bits;
    logic    res_push;
    result_t res_data;
    logic    out_full, out_empty;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic [$bits(result_t)-1:0]     out_bits;
    result_t out_word;

    // Start state register and the clearing pass counter.
    always_comb begin
        init_state_next = cfg_wr_en ? cfg_wr_data : init_state_reg;
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg) begin
            clr_cnt_next = clr_cnt_reg + CLR_W'(1);
            if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1)) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_state_reg <= '0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end else begin
            init_state_reg <= init_state_next;
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    // Unpack the input word.
    always_comb begin
        in_item             = '0;
        in_item.cmd         = cmd_e'(s_tuser);
        in_item.char_byte   = s_tdata[7:0];
        in_item.eos         = s_tlast;
        in_item.from_state  = s_tdata[13:8];
        in_item.class_code  = s_tdata[21:14];
        in_item.to_state    = s_tdata[27:22];
        in_item.entry_valid = s_tdata[28];
        in_item.final_flag  = s_tdata[29];
    end

    dla_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clr_active (clr_active_reg),
        .clr_addr   (clr_cnt_reg[BYTE_W-1:0]),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_data)
    );

    dla_queue #(
        .WIDTH ($bits(item_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .pop_data  (q_head_bits),
        .full      (q_full),
        .empty     (q_empty),
        .count     ()
    );

    dla_back #(
        .STATE_COUNT (STATE_COUNT),
        .CLASS_COUNT (CLASS_COUNT),
        .MAX_LENGTH  (MAX_LENGTH),
        .CLR_W       (CLR_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clr_active  (clr_active_reg),
        .clr_addr    (clr_cnt_reg),
        .init_state  (init_state_reg),
        .q_empty     (q_empty),
        .q_head      (item_t'(q_head_bits)),
        .q_pop       (q_pop),
        .out_count   (out_count),
        .res_push    (res_push),
        .res_data    (res_data)
    );

    dla_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .pop       (m_tvalid && m_tready),
        .pop_data  (out_bits),
        .full      (out_full),
        .empty     (out_empty),
        .count     (out_count)
    );

    // Pack the result word.
    always_comb begin
        out_word = result_t'(out_bits);
        m_tvalid = !out_empty;
        m_tdata  = {(M_TDATA_W - LEN_W - 2)'(0), out_word.length_overflow,
                    out_word.accepted, out_word.prefix_length};
    end

    // No word is taken while the tables are being cleared.
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_tready)
        else $error("input taken during the clearing pass");

    // The back end reserves output room before it produces a result.
    a_out_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> !out_full)
        else $error("result produced into a full output queue");

    // The clearing pass runs once after reset.
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clr_active_reg |=> !clr_active_reg)
        else $error("clearing pass restarted");

endmodule
